@@ rtl/vlrs_pkg.sv @@
// ----------------------------------------------------------------------------
// vlrs_pkg: shared types and defaults for the variable-length record stack
// Holds the action codes, default sizes and the command and status bundles
// that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package vlrs_pkg;

    localparam int STACK_BYTES_DEF    = 1024;
    localparam int LEN_WORD_BYTES_DEF = 2;
    localparam int MAX_RES            = 64;   // most bytes returned by one pop or peek
    localparam int WANT_W             = 7;    // width of the requested byte count

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;    // open the input channel
        logic push_byte;   // store the pending push byte, update count and overflow
        logic push_emit;   // load the push acknowledge into the output register
        logic commit;      // run the commit check and arm the length word
        logic len_write;   // write one length word byte
        logic clear_top;   // empty the stack
        logic drop_push;   // abandon any pending push
        logic set_ok;      // load the response status
        logic ok_val;
        logic len_start;   // point at the top length word
        logic mem_read;    // read the byte at the working pointer
        logic len_shift;   // shift the read byte into the length word
        logic clamp;       // clamp the stored length to what is held
        logic base;        // compute record base and byte count
        logic byte_emit;   // load a record byte into the output register
        logic resp_emit;   // load a single response into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic    in_take;       // input transfer this cycle
        t_action act;
        logic    is_last;
        logic    top_zero;      // no committed records
        logic    commit_ok;
        logic    len_done;      // last byte of the length word
        logic    none_to_send;  // pop or peek returns no bytes
        logic    byte_last;     // final record byte of this item
        logic    out_free;      // output register can take a result
    } t_dp_sts;

endpackage

@@ rtl/vlrs_in_if.sv @@
// ----------------------------------------------------------------------------
// vlrs_in_if: input item channel of the record stack
// One operation per transfer: push byte, pop, peek or clear.
// ----------------------------------------------------------------------------
interface vlrs_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
    logic [6:0] want_len;

    modport source (
        output valid, action, data_byte, has_byte, is_last, want_len,
        input  ready
    );

    modport sink (
        input  valid, action, data_byte, has_byte, is_last, want_len,
        output ready
    );

endinterface

@@ rtl/vlrs_out_if.sv @@
// ----------------------------------------------------------------------------
// vlrs_out_if: result channel of the record stack
// One result per transfer; free_bytes width follows the memory size.
// ----------------------------------------------------------------------------
interface vlrs_out_if
    import vlrs_pkg::*;
#(
    parameter int FREE_W = $clog2(STACK_BYTES_DEF + 1)
);

    logic              valid;
    logic              ready;
    logic              ok;
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              last;
    logic              empty_res;
    logic [FREE_W-1:0] free_bytes;

    modport source (
        output valid, ok, out_byte, byte_valid, last, empty_res, free_bytes,
        input  ready
    );

    modport sink (
        input  valid, ok, out_byte, byte_valid, last, empty_res, free_bytes,
        output ready
    );

endinterface

@@ rtl/vlrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// vlrs_ctrl: sequencer of the record stack
// Steps each accepted item through push, commit, length word access, byte
// walk or a single response, and hands commands to the datapath.
// ----------------------------------------------------------------------------
module vlrs_ctrl
    import vlrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_EXEC   = 11'b000_0000_0010,
        S_COMMIT = 11'b000_0000_0100,
        S_LENW   = 11'b000_0000_1000,
        S_LRD    = 11'b000_0001_0000,
        S_LCAP   = 11'b000_0010_0000,
        S_CLAMP  = 11'b000_0100_0000,
        S_BASE   = 11'b000_1000_0000,
        S_BRD    = 11'b001_0000_0000,
        S_BOUT   = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_take) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_sts.act)
                    ACT_PUSH: begin
                        if (i_sts.is_last) begin
                            o_cmd.push_byte = 1'b1;
                            n_state         = S_COMMIT;
                        end else if (i_sts.out_free) begin
                            o_cmd.push_byte = 1'b1;
                            o_cmd.push_emit = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.drop_push = 1'b1;
                        o_cmd.clear_top = 1'b1;
                        o_cmd.set_ok    = 1'b1;
                        o_cmd.ok_val    = 1'b1;
                        n_state         = S_RESP;
                    end
                    ACT_POP, ACT_PEEK: begin
                        o_cmd.drop_push = 1'b1;
                        if (i_sts.top_zero) begin
                            o_cmd.set_ok = 1'b1;
                            o_cmd.ok_val = 1'b0;
                            n_state      = S_RESP;
                        end else begin
                            o_cmd.len_start = 1'b1;
                            n_state         = S_LRD;
                        end
                    end
                endcase
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = i_sts.commit_ok ? S_LENW : S_RESP;
            end
            S_LENW: begin
                o_cmd.len_write = 1'b1;
                if (i_sts.len_done) n_state = S_RESP;
            end
            S_LRD: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_LCAP;
            end
            S_LCAP: begin
                o_cmd.len_shift = 1'b1;
                n_state         = i_sts.len_done ? S_CLAMP : S_LRD;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                if (i_sts.none_to_send) begin
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_BOUT;
            end
            S_BOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.byte_emit = 1'b1;
                    n_state         = i_sts.byte_last ? S_IDLE : S_BRD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/vlrs_dp.sv @@
// ----------------------------------------------------------------------------
// vlrs_dp: datapath of the record stack
// Byte memory, stack pointers, pending push state, length word assembly and
// the result register.
// ----------------------------------------------------------------------------
module vlrs_dp
    import vlrs_pkg::*;
#(
    parameter int STACK_BYTES    = STACK_BYTES_DEF,
    parameter int LEN_WORD_BYTES = LEN_WORD_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vlrs_in_if.sink      i_item,
    vlrs_out_if.source   o_result,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts
);

    localparam int AW  = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1;
    localparam int CW  = $clog2(STACK_BYTES + 1);
    localparam int SW  = CW + 1;
    localparam int LWW = 8 * LEN_WORD_BYTES;
    localparam int JW  = (LEN_WORD_BYTES > 1) ? $clog2(LEN_WORD_BYTES) : 1;
    localparam int MW  = (LWW > CW) ? LWW : CW;
    localparam int KW  = (CW > WANT_W) ? CW : WANT_W;

    // Memory
    logic [7:0]        r_mem [STACK_BYTES];
    logic [7:0]        r_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;

    // Captured item
    t_action           r_act;
    logic [7:0]        r_data;
    logic              r_has;
    logic              r_last;
    logic [WANT_W-1:0] r_want;

    // Stack state
    logic [CW-1:0]     r_top;
    logic [CW-1:0]     r_count;
    logic              r_ovf;

    // Working registers
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_lw;
    logic [CW-1:0]     r_stc;
    logic [LWW-1:0]    r_lword;
    logic [JW-1:0]     r_j;
    logic [WANT_W-1:0] r_cnt;
    logic              r_ok;

    // Result register
    logic              r_out_valid;
    logic              r_o_ok;
    logic [7:0]        r_o_byte;
    logic              r_o_bv;
    logic              r_o_last;
    logic              r_o_empty;
    logic [CW-1:0]     r_o_free;

    logic              in_take;
    logic              out_free;
    logic              any_emit;
    logic [CW-1:0]     push_addr;
    logic              push_in;
    logic              push_wr;
    logic              ovf_push;
    logic [SW-1:0]     commit_sum;
    logic              len_fits;
    logic              commit_ok;
    logic [CW-1:0]     lw;
    logic [CW-1:0]     base_v;
    logic [WANT_W-1:0] want_sat;
    logic [WANT_W-1:0] n_send;

    assign in_take  = i_item.valid && i_cmd.in_ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign any_emit = i_cmd.push_emit || i_cmd.byte_emit || i_cmd.resp_emit;

    // Pending push byte address and overflow
    assign push_addr = r_top + r_count;
    assign push_in   = push_addr < CW'(STACK_BYTES);
    assign push_wr   = r_has && !r_ovf && push_in;
    assign ovf_push  = r_ovf || (r_has && !push_in);

    // Commit check
    assign commit_sum = SW'(push_addr) + SW'(LEN_WORD_BYTES);
    assign len_fits   = (MW'(r_count) >> LWW) == '0;
    assign commit_ok  = !r_ovf && len_fits && (commit_sum <= SW'(STACK_BYTES));

    // Length word position, saturating at address zero
    assign lw = (r_top >= CW'(LEN_WORD_BYTES)) ? r_top - CW'(LEN_WORD_BYTES) : '0;

    // Record base and byte count
    assign base_v   = r_lw - r_stc;
    assign want_sat = (r_want > WANT_W'(MAX_RES)) ? WANT_W'(MAX_RES) : r_want;
    assign n_send   = (KW'(want_sat) > KW'(r_stc)) ? WANT_W'(r_stc) : want_sat;

    assign mem_we    = (i_cmd.push_byte && push_wr) || i_cmd.len_write;
    assign mem_waddr = i_cmd.len_write ? r_ptr[AW-1:0] : push_addr[AW-1:0];
    assign mem_wdata = i_cmd.len_write ? r_lword[7:0] : r_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.mem_read) r_rd <= r_mem[r_ptr[AW-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push_byte) begin
                if (push_wr) r_count <= r_count + CW'(1);
                r_ovf <= ovf_push;
            end
            if (i_cmd.commit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                if (commit_ok) r_top <= CW'(commit_sum);
            end
            if (i_cmd.drop_push) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.clear_top) r_top <= '0;
            if (i_cmd.base && (r_act == ACT_POP)) r_top <= base_v;

            if (any_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_act  <= t_action'(i_item.action);
            r_data <= i_item.data_byte;
            r_has  <= i_item.has_byte;
            r_last <= i_item.is_last;
            r_want <= i_item.want_len;
        end
        if (i_cmd.commit) begin
            r_ok <= commit_ok;
            r_j  <= '0;
            if (commit_ok) begin
                r_ptr   <= push_addr;
                r_lword <= LWW'(r_count);
            end
        end
        if (i_cmd.len_write) begin
            r_lword <= r_lword >> 8;
            r_ptr   <= r_ptr + CW'(1);
            r_j     <= r_j + JW'(1);
        end
        if (i_cmd.set_ok) r_ok <= i_cmd.ok_val;
        if (i_cmd.len_start) begin
            r_lw  <= lw;
            r_ptr <= lw;
            r_j   <= '0;
        end
        if (i_cmd.len_shift) begin
            r_lword <= (r_lword >> 8) | (LWW'(r_rd) << (LWW - 8));
            r_ptr   <= r_ptr + CW'(1);
            r_j     <= r_j + JW'(1);
        end
        if (i_cmd.clamp) begin
            r_stc <= (MW'(r_lword) > MW'(r_lw)) ? r_lw : CW'(r_lword);
        end
        if (i_cmd.base) begin
            r_ptr <= base_v;
            r_cnt <= n_send;
        end
        if (i_cmd.byte_emit) begin
            r_ptr <= r_ptr + CW'(1);
            r_cnt <= r_cnt - WANT_W'(1);
        end

        // Snapshot the result; stack status comes from the settled top
        if (any_emit) begin
            r_o_empty <= (r_top == '0);
            r_o_free  <= CW'(STACK_BYTES) - r_top;
            r_o_last  <= i_cmd.byte_emit ? (r_cnt == WANT_W'(1)) : 1'b1;
            r_o_bv    <= i_cmd.byte_emit;
            r_o_byte  <= i_cmd.byte_emit ? r_rd : 8'd0;
            if (i_cmd.push_emit) begin
                r_o_ok <= !ovf_push;
            end else if (i_cmd.byte_emit) begin
                r_o_ok <= 1'b1;
            end else begin
                r_o_ok <= r_ok;
            end
        end
    end

    assign i_item.ready        = i_cmd.in_ready;
    assign o_result.valid      = r_out_valid;
    assign o_result.ok         = r_o_ok;
    assign o_result.out_byte   = r_o_byte;
    assign o_result.byte_valid = r_o_bv;
    assign o_result.last       = r_o_last;
    assign o_result.empty_res  = r_o_empty;
    assign o_result.free_bytes = r_o_free;

    assign o_sts.in_take      = in_take;
    assign o_sts.act          = r_act;
    assign o_sts.is_last      = r_last;
    assign o_sts.top_zero     = (r_top == '0);
    assign o_sts.commit_ok    = commit_ok;
    assign o_sts.len_done     = (r_j == JW'(LEN_WORD_BYTES - 1));
    assign o_sts.none_to_send = (n_send == '0);
    assign o_sts.byte_last    = (r_cnt == WANT_W'(1));
    assign o_sts.out_free     = out_free;

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_emit |-> out_free)
        else $error("result loaded over an untaken result");

    a_push_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_top) + SW'(r_count)) <= SW'(STACK_BYTES))
        else $error("pending push runs past the memory");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.base && (r_act == ACT_POP)) |=> (r_top <= $past(r_top)))
        else $error("pop grew the stack");

    a_byte_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.byte_emit |-> (r_cnt != '0))
        else $error("record byte sent with no bytes left");
`endif

endmodule

@@ rtl/variable_length_record_stack.sv @@
// ----------------------------------------------------------------------------
// variable_length_record_stack: byte-memory stack of variable-length records
// Records are stored as their bytes followed by a little-endian length word.
// ----------------------------------------------------------------------------
// Push streams one byte per transfer into memory just above the committed top;
// the transfer marked is_last commits the record only when its bytes plus the
// LEN_WORD_BYTES length word fit, otherwise the stack is left as it was. Pop
// and peek read the top length word and return the first min(want_len, stored
// length, 64) bytes from the record's base, one result per byte, last marking
// the final one; pop also removes the record. Clear empties the stack. Every
// result reports empty_res and free_bytes after the operation. The sequence
// follows the byte memory with its registered read: a push byte that is not
// last is stored and acknowledged; a last push byte runs the commit check
// and, when the record commits, writes the length word one byte at a time
// before its response; clear, and pop or peek on an empty stack, give one
// response; a pop or peek reads the length word byte by byte, then reads and
// sends each record byte in turn (one read and one result per byte), or
// gives a single response when it returns none. Stalls on the result
// channel hold the sequence. The next item is taken while the last result
// still waits in the output register. Memory contents are undefined after
// reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module variable_length_record_stack
    import vlrs_pkg::*;
#(
    parameter int STACK_BYTES    = STACK_BYTES_DEF,
    parameter int LEN_WORD_BYTES = LEN_WORD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vlrs_in_if.sink     i_item,
    vlrs_out_if.source  o_result
);

    // Command and status between the sequencer and the datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence each item: accept, execute, then commit, length word access,
    // byte walk or a single response as the action calls for
    vlrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold the memory, pointers and the result register; drive both channels
    vlrs_dp #(
        .STACK_BYTES    (STACK_BYTES),
        .LEN_WORD_BYTES (LEN_WORD_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

endmodule

@@ test/variable_length_record_stack_tb.sv @@
// ----------------------------------------------------------------------------
// variable_length_record_stack_tb: self-checking bench for the record stack
// Streams push, pop, peek and clear transfers into the block and checks every
// result field against an in-bench model of the byte memory and its top.
// Results are compared in order. Random idling on both channels is stopped for
// one long stretch.
// ----------------------------------------------------------------------------
module variable_length_record_stack_tb;
    import vlrs_pkg::*;

    localparam int STACK_SIZE = STACK_BYTES_DEF;
    localparam int LEN_BYTES  = LEN_WORD_BYTES_DEF;
    localparam int FREE_W     = $clog2(STACK_SIZE + 1);
    localparam int IDLE_PCT   = 28;     // chance per cycle that a side idles
    localparam int RAND_OPS   = 240;    // size of the random section

    // One operation on the input channel; wait_drain holds it back until
    // every outstanding result has been taken.
    typedef struct {
        t_action    act;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
        logic [6:0] want_len;
        bit         wait_drain;
    } t_op;

    typedef struct {
        logic              ok;
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              last;
        logic              empty_res;
        logic [FREE_W-1:0] free_bytes;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vlrs_in_if  item_ch ();
    vlrs_out_if result_ch ();

    variable_length_record_stack uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the stack: memory, committed top, pending push bytes and
    // the overflow flag of the push in progress.
    // ------------------------------------------------------------------------
    logic [7:0]  stack_mem [STACK_SIZE];
    int unsigned stack_top;
    int unsigned pend_count;
    bit          pend_ovf;

    t_op     pending_ops [$];   // operations not yet transferred
    t_result due_results [$];   // results predicted but not yet seen
    t_op     in_flight;         // operation currently offered to the block

    int n_items, n_results, n_refused, n_bytes_read, n_errors;

    // Hold both sides busy-free through one long stretch of the random section.
    wire calm = (n_items >= 90) && (n_items < 170);

    // Stack-wide status is taken after the operation has changed the top.
    function automatic t_result status(bit ok, logic [7:0] b, bit bv, bit last);
        t_result r;
        r.ok         = ok;
        r.out_byte   = bv ? b : 8'd0;
        r.byte_valid = bv;
        r.last       = last;
        r.empty_res  = (stack_top == 0);
        r.free_bytes = FREE_W'(STACK_SIZE - stack_top);
        return r;
    endfunction

    // Advance the shadow stack by one transferred operation and queue the
    // results that it must produce.
    task automatic apply_op(input t_op op);
        int unsigned       addr, lw, base, n;
        longint unsigned   stored;
        logic [7:0]        read_back [$];
        bit                ok;
        n_items++;
        if (op.act == ACT_PUSH) begin
            // Write the byte just above the top unless the memory ran out.
            if (op.has_byte && !pend_ovf) begin
                addr = stack_top + pend_count;
                if (addr < STACK_SIZE) begin
                    stack_mem[addr] = op.data_byte;
                    pend_count++;
                end else begin
                    pend_ovf = 1'b1;
                end
            end
            if (!op.is_last) begin
                due_results.push_back(status(!pend_ovf, 8'd0, 1'b0, 1'b1));
                return;
            end
            // Commit only when bytes plus the length word fit.
            ok = !pend_ovf && ((longint'(pend_count) >> (8 * LEN_BYTES)) == 0) &&
                 (pend_count + LEN_BYTES <= STACK_SIZE - stack_top);
            if (ok) begin
                for (int i = 0; i < LEN_BYTES; i++)
                    stack_mem[stack_top + pend_count + i] = 8'(pend_count >> (8 * i));
                stack_top = stack_top + pend_count + LEN_BYTES;
            end else begin
                n_refused++;
            end
            pend_count = 0;
            pend_ovf   = 1'b0;
            due_results.push_back(status(ok, 8'd0, 1'b0, 1'b1));
            return;
        end

        // Any other action drops a push in progress.
        pend_count = 0;
        pend_ovf   = 1'b0;
        if (op.act == ACT_CLEAR) begin
            stack_top = 0;
            due_results.push_back(status(1'b1, 8'd0, 1'b0, 1'b1));
            return;
        end
        if (stack_top == 0) begin
            due_results.push_back(status(1'b0, 8'd0, 1'b0, 1'b1));
            return;
        end

        // Length word sits just below the top, least significant byte first.
        lw     = (stack_top >= LEN_BYTES) ? stack_top - LEN_BYTES : 0;
        stored = 0;
        for (int j = LEN_BYTES - 1; j >= 0; j--)
            stored = (stored << 8) | ((lw + j < STACK_SIZE) ? stack_mem[lw + j] : 8'd0);
        if (stored > lw)
            stored = lw;
        base = lw - int'(stored);
        n    = op.want_len;
        if (n > stored)
            n = int'(stored);
        if (n > MAX_RES)
            n = MAX_RES;
        for (int i = 0; i < n; i++)
            read_back.push_back(stack_mem[(base + i) % STACK_SIZE]);
        if (op.act == ACT_POP)
            stack_top = base;
        n_bytes_read += n;
        if (n == 0) begin
            due_results.push_back(status(1'b1, 8'd0, 1'b0, 1'b1));
        end else begin
            for (int i = 0; i < n; i++)
                due_results.push_back(status(1'b1, read_back[i], 1'b1, i == n - 1));
        end
    endtask

    task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
        n_errors++;
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next queued operation when the channel is free, or
    // idle at random. Valid is assigned once per edge so a back-to-back
    // transfer keeps it high.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit taken, offer;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            taken = item_ch.valid && item_ch.ready;
            if (taken)
                apply_op(in_flight);
            if (!item_ch.valid || taken) begin
                offer = (pending_ops.size() != 0) &&
                        !(pending_ops[0].wait_drain && (taken || due_results.size() != 0)) &&
                        (calm || $urandom_range(0, 99) >= IDLE_PCT);
                if (offer) begin
                    in_flight = pending_ops.pop_front();
                    item_ch.action    <= in_flight.act;
                    item_ch.data_byte <= in_flight.data_byte;
                    item_ch.has_byte  <= in_flight.has_byte;
                    item_ch.is_last   <= in_flight.is_last;
                    item_ch.want_len  <= in_flight.want_len;
                end
                item_ch.valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction, then
    // pick the next ready at random.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    note_mismatch("result with nothing outstanding", 0, 1);
                end else begin
                    due = due_results.pop_front();
                    if (result_ch.ok !== due.ok)
                        note_mismatch("ok", due.ok, result_ch.ok);
                    if (result_ch.out_byte !== due.out_byte)
                        note_mismatch("out_byte", due.out_byte, result_ch.out_byte);
                    if (result_ch.byte_valid !== due.byte_valid)
                        note_mismatch("byte_valid", due.byte_valid, result_ch.byte_valid);
                    if (result_ch.last !== due.last)
                        note_mismatch("last", due.last, result_ch.last);
                    if (result_ch.empty_res !== due.empty_res)
                        note_mismatch("empty_res", due.empty_res, result_ch.empty_res);
                    if (result_ch.free_bytes !== due.free_bytes)
                        note_mismatch("free_bytes", due.free_bytes, result_ch.free_bytes);
                end
            end
            result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus building. plan_top and plan_recs follow the committed records
    // as the operations are queued.
    // ------------------------------------------------------------------------
    int         plan_top;
    int         plan_recs [$];
    bit         drain_next;
    logic [7:0] fixed_bytes [$];    // bytes to use before falling back to random

    task automatic add_op(t_action act, logic [7:0] b, bit hb, bit lst, logic [6:0] want);
        t_op op;
        op.act        = act;
        op.data_byte  = b;
        op.has_byte   = hb;
        op.is_last    = lst;
        op.want_len   = want;
        op.wait_drain = drain_next;
        drain_next    = 1'b0;
        pending_ops.push_back(op);
    endtask

    // Stream one record. tail_empty ends it with a byteless last transfer;
    // gap_pct sprinkles byteless transfers in between.
    task automatic add_record(int len, bit tail_empty, int gap_pct);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < gap_pct)
                add_op(ACT_PUSH, 8'($urandom), 1'b0, 1'b0, 7'($urandom));
            b = (fixed_bytes.size() != 0) ? fixed_bytes.pop_front() : 8'($urandom);
            add_op(ACT_PUSH, b, 1'b1, !tail_empty && (i == len - 1), 7'($urandom));
        end
        if (tail_empty || len == 0)
            add_op(ACT_PUSH, 8'($urandom), 1'b0, 1'b1, 7'($urandom));
        if (len + LEN_BYTES <= STACK_SIZE - plan_top) begin
            plan_top += len + LEN_BYTES;
            plan_recs.push_back(len);
        end
    endtask

    // Push bytes that never see a last transfer; the next action drops them.
    task automatic add_abandoned(int len);
        for (int i = 0; i < len; i++)
            add_op(ACT_PUSH, 8'($urandom), 1'($urandom), 1'b0, 7'($urandom));
    endtask

    task automatic add_fetch(t_action act, int want);
        add_op(act, 8'($urandom), 1'($urandom), 1'($urandom), 7'(want));
        if (act == ACT_POP && plan_recs.size() != 0)
            plan_top -= plan_recs.pop_back() + LEN_BYTES;
    endtask

    task automatic add_clear();
        add_op(ACT_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
        plan_top = 0;
        plan_recs.delete();
    endtask

    function automatic int pick_want();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    endfunction

    initial begin
        int start, pick;
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.action     = ACT_PUSH;
        item_ch.data_byte  = 8'd0;
        item_ch.has_byte   = 1'b0;
        item_ch.is_last    = 1'b0;
        item_ch.want_len   = 7'd0;
        result_ch.ready    = 1'b0;
        stack_top  = 0;
        pend_count = 0;
        pend_ovf   = 1'b0;
        foreach (stack_mem[i])
            stack_mem[i] = 8'd0;

        // Directed: empty-stack answers, empty record, byte extremes,
        // zero-byte requests, dropped pushes, byteless terminator.
        add_fetch(ACT_POP, 5);
        add_fetch(ACT_PEEK, 127);
        add_clear();
        add_record(0, 1'b0, 0);
        add_fetch(ACT_PEEK, 10);
        fixed_bytes = '{8'h00, 8'hFF, 8'hA5};
        add_record(3, 1'b0, 0);
        add_fetch(ACT_PEEK, 0);
        add_fetch(ACT_PEEK, 127);
        add_fetch(ACT_POP, 2);
        add_abandoned(2);
        add_fetch(ACT_POP, 1);
        add_fetch(ACT_POP, 3);
        fixed_bytes = '{8'h5A};
        add_record(1, 1'b1, 0);
        add_abandoned(1);
        add_clear();
        add_fetch(ACT_PEEK, 64);

        // Random: mostly well-formed records, with dropped pushes and fetches.
        drain_next = 1'b1;
        start = pending_ops.size();
        while (pending_ops.size() - start < RAND_OPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                add_record(($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                                       : $urandom_range(0, 8),
                           $urandom_range(0, 3) == 0, 10);
            end else if (pick < 60) begin
                add_abandoned($urandom_range(1, 4));
                case ($urandom_range(0, 2))
                    0: add_fetch(ACT_POP, pick_want());
                    1: add_fetch(ACT_PEEK, pick_want());
                    default: add_clear();
                endcase
            end else if (pick < 80) begin
                add_fetch(ACT_POP, pick_want());
            end else if (pick < 95) begin
                add_fetch(ACT_PEEK, pick_want());
            end else begin
                add_clear();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let everything drain, then allow a short tail for stray results.
        while (pending_ops.size() != 0 || item_ch.valid)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("summary: %0d operations in, %0d results out, %0d pushes refused",
                 n_items, n_results, n_refused);
        $display("summary: %0d record bytes read back across pops and peeks",
                 n_bytes_read);
        if (n_errors == 0)
            $display("variable_length_record_stack_tb: done, clean");
        else
            $display("variable_length_record_stack_tb: done, errors");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("variable_length_record_stack_tb: done, errors");
        $finish;
    end

endmodule
